[design/mra_pkg.sv]
// ----------------------------------------------------------------------------
// mra_pkg
// Shared types and constants of the masked rmse accumulator.
// ----------------------------------------------------------------------------
package mra_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CHANNELS = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd1;
  localparam logic [2:0] REG_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_USE_MASK = 3'd3;
  localparam logic [2:0] REG_BOUNDARY = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SMALL = 2'd2;

  // reset values of the registers
  localparam logic [2:0]  RST_CHANNELS = 3'd1;
  localparam logic [12:0] RST_WIDTH    = 13'd640;
  localparam logic [15:0] RST_HEIGHT   = 16'd480;

  // last iteration indexes of the divider and square root counters
  localparam logic [6:0] DIV_LAST  = 7'd95;
  localparam logic [6:0] ROOT_LAST = 7'd31;

  // divisor is channels squared times pixel count
  localparam int DIVISOR_W = 37;
  // effective width holds any legal maximum row length
  localparam int WEFF_W    = 15;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic calc;
    logic upd;
    logic prep;
    logic div_step;
    logic root_load;
    logic root_step;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic frame_end;
    logic err;
  } sts_t;

endpackage

[design/mra_ifs.sv]
// ----------------------------------------------------------------------------
// mra channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface mra_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] img_ch0;
  logic [15:0] img_ch1;
  logic [15:0] img_ch2;
  logic [15:0] img_ch3;
  logic [15:0] ref_ch0;
  logic [15:0] ref_ch1;
  logic [15:0] ref_ch2;
  logic [15:0] ref_ch3;
  logic        mask_selected;

  modport source (
    output valid, img_ch0, img_ch1, img_ch2, img_ch3,
    output ref_ch0, ref_ch1, ref_ch2, ref_ch3, mask_selected,
    input  ready
  );
  modport sink (
    input  valid, img_ch0, img_ch1, img_ch2, img_ch3,
    input  ref_ch0, ref_ch1, ref_ch2, ref_ch3, mask_selected,
    output ready
  );
endinterface

interface mra_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] rmse;
  logic [1:0]  status;

  modport source (output valid, rmse, status, input ready);
  modport sink (input valid, rmse, status, output ready);
endinterface

interface mra_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[design/mra_ctrl.sv]
// ----------------------------------------------------------------------------
// mra_ctrl
// Sequencer: clearing pass, per-pixel steps, frame-end divide and root.
// ----------------------------------------------------------------------------
module mra_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mra_pkg::sts_t    sts,
  output mra_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CALC  = 9'b000000100,
    S_UPD   = 9'b000001000,
    S_PREP  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_LOAD  = 9'b001000000,
    S_ROOT  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = sts.frame_end ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = mra_pkg::DIV_LAST;
        state_nxt = sts.err ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 7'd1;
        if (cnt_r == '0) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.root_load = 1'b1;
        cnt_nxt       = mra_pkg::ROOT_LAST;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r - 7'd1;
        if (cnt_r == '0) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[design/mra_datapath.sv]
// ----------------------------------------------------------------------------
// mra_datapath
// Registers, line stores, accumulator, divider and square root unit.
// ----------------------------------------------------------------------------
module mra_datapath #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mra_pkg::cmd_t        cmd,
  output mra_pkg::sts_t        sts,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [15:0]          cfg_data,
  input  logic [3:0][15:0]     img_s,
  input  logic [3:0][15:0]     ref_s,
  input  logic                 mask_in,
  output logic [31:0]          rmse,
  output logic [1:0]           status
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int SUMW = SAMPLE_BITS + 2;
  localparam int SQW  = 2 * SUMW;
  localparam int DW   = mra_pkg::DIVISOR_W;
  localparam int EW   = mra_pkg::WEFF_W;

  // configuration
  logic [2:0]  chan_r;
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic        use_mask_r, bnd_r;

  // pixel and frame state
  logic [3:0][15:0] img_r, ref_r;
  logic             m_r;
  logic [1:0]       mask_rd_r;
  logic [SQW-1:0]   diff_rd_r, sq_r, delay_r;
  logic [CW-1:0]    col_r, clr_addr_r;
  logic [15:0]      row_r;
  logic [63:0]      sum_r;
  logic [31:0]      cnt_r;
  logic [8:0]       win_r;
  logic [1:0]       status_r;

  // divider and root
  logic [DW-1:0] d_r, rem_r;
  logic [63:0]   q_r, sh_r;
  logic          sat_r;
  logic [63:0]   x_r, res_r, bit_r;

  logic [1:0]     mask_mem [MAX_WIDTH];
  logic [SQW-1:0] diff_mem [MAX_WIDTH];

  // effective register values
  logic [2:0]    n_eff;
  logic [EW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [4:0]    nn;

  always_comb begin
    if (chan_r == '0) n_eff = 3'd1;
    else if (chan_r > 3'(MAX_CHANNELS)) n_eff = 3'(MAX_CHANNELS);
    else n_eff = chan_r;
    if (width_r == '0) w_eff = EW'(1);
    else if (EW'(width_r) > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else w_eff = EW'(width_r);
    h_eff = (height_r == '0) ? 16'd1 : height_r;
    nn    = 5'({2'b0, n_eff} * {2'b0, n_eff});
  end

  // grey difference squared over channel sums
  logic [SUMW-1:0] si, sr, ad;
  logic [SQW-1:0]  sq_nxt;

  always_comb begin
    si = '0;
    sr = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (3'(k) < n_eff) begin
        si = si + SUMW'(img_r[k][SAMPLE_BITS-1:0]);
        sr = sr + SUMW'(ref_r[k][SAMPLE_BITS-1:0]);
      end
    end
    ad     = (si >= sr) ? si - sr : sr - si;
    sq_nxt = SQW'(ad) * SQW'(ad);
  end

  // window, qualification and accumulate
  logic           p, up2, up1, bmode, add_en, row_end, frame_end;
  logic [8:0]     win_nxt;
  logic [SQW-1:0] add_val;
  logic [64:0]    sum_add;
  logic [63:0]    sum_nxt;
  logic [31:0]    cnt_nxt;
  logic [1:0]     wr_word, status_nxt;

  always_comb begin
    p       = row_r[0];
    up2     = mask_rd_r[p];
    up1     = mask_rd_r[~p];
    win_nxt = {win_r[5:0], up2, up1, m_r};
    wr_word = p ? {m_r, mask_rd_r[0]} : {mask_rd_r[1], m_r};
    bmode   = use_mask_r & bnd_r;
    if (bmode) begin
      add_en  = (row_r >= 16'd2) && (col_r >= CW'(2)) && (win_nxt != '0) && (win_nxt != '1);
      add_val = delay_r;
    end else begin
      add_en  = !use_mask_r || m_r;
      add_val = sq_r;
    end
    sum_add = {1'b0, sum_r} + (add_en ? 65'(add_val) : 65'd0);
    sum_nxt = sum_add[64] ? '1 : sum_add[63:0];
    cnt_nxt = (add_en && cnt_r != '1) ? cnt_r + 32'd1 : cnt_r;
    row_end   = (EW'(col_r) + EW'(1)) >= w_eff;
    frame_end = row_end && ((17'(row_r) + 17'd1) >= 17'(h_eff));
    if (bmode && (w_eff < EW'(3) || h_eff < 16'd3)) status_nxt = mra_pkg::ST_SMALL;
    else if (cnt_nxt == '0) status_nxt = mra_pkg::ST_EMPTY;
    else status_nxt = mra_pkg::ST_OK;
  end

  // divider step, one quotient bit a cycle
  logic [DW-1:0] r_sh;
  logic          ge;
  always_comb begin
    r_sh = {rem_r[DW-2:0], sh_r[63]};
    ge   = r_sh >= d_r;
  end

  // root step
  logic [63:0] t_root;
  assign t_root = res_r + bit_r;

  assign sts.clr_last  = (clr_addr_r == CW'(MAX_WIDTH - 1));
  assign sts.frame_end = frame_end;
  assign sts.err       = (status_r != mra_pkg::ST_OK);

  assign rmse   = (status_r == mra_pkg::ST_OK) ? res_r[31:0] : 32'd0;
  assign status = status_r;

  // line stores
  always_ff @(posedge clk) begin
    if (cmd.clr) mask_mem[clr_addr_r] <= '0;
    else if (cmd.upd) mask_mem[col_r] <= wr_word;
    if (cmd.load_in) mask_rd_r <= mask_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) diff_mem[col_r] <= sq_r;
    if (cmd.load_in) diff_rd_r <= diff_mem[col_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r     <= mra_pkg::RST_CHANNELS;
      width_r    <= mra_pkg::RST_WIDTH;
      height_r   <= mra_pkg::RST_HEIGHT;
      use_mask_r <= 1'b0;
      bnd_r      <= 1'b0;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
      win_r      <= '0;
      delay_r    <= '0;
      status_r   <= mra_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mra_pkg::REG_CHANNELS: chan_r     <= cfg_data[2:0];
          mra_pkg::REG_WIDTH:    width_r    <= cfg_data[12:0];
          mra_pkg::REG_HEIGHT:   height_r   <= cfg_data;
          mra_pkg::REG_USE_MASK: use_mask_r <= cfg_data[0];
          mra_pkg::REG_BOUNDARY: bnd_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clr) clr_addr_r <= clr_addr_r + CW'(1);
      if (cmd.upd) begin
        win_r   <= win_nxt;
        delay_r <= diff_rd_r;
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
        if (row_end) begin
          col_r <= '0;
          if (!frame_end) row_r <= row_r + 16'd1;
        end else begin
          col_r <= col_r + CW'(1);
        end
        if (frame_end) status_r <= status_nxt;
      end
      if (cmd.prep) begin
        row_r   <= '0;
        sum_r   <= '0;
        cnt_r   <= '0;
        win_r   <= '0;
        delay_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      img_r <= img_s;
      ref_r <= ref_s;
      m_r   <= mask_in;
    end
    if (cmd.calc) sq_r <= sq_nxt;
    if (cmd.prep) begin
      d_r   <= DW'(nn) * DW'(cnt_r);
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
      sh_r  <= sum_r;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? r_sh - d_r : r_sh;
      q_r   <= {q_r[62:0], ge};
      sh_r  <= {sh_r[62:0], 1'b0};
      if (q_r[63]) sat_r <= 1'b1;
    end
    if (cmd.root_load) begin
      x_r   <= sat_r ? '1 : q_r;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end
    if (cmd.root_step) begin
      if (x_r >= t_root) begin
        x_r   <= x_r - t_root;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

[design/masked_rmse_accumulator.sv]
// ----------------------------------------------------------------------------
// masked_rmse_accumulator
// Streaming masked rmse between an image and a reference, one result a frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on in_ch, one word per pixel with four image
// and four reference samples and a mask bit. After the last pixel of a frame
// one word leaves on out_ch: the rmse in unsigned 16.16 and a status.
// cfg_ch writes the five registers (channels, width, height, use mask,
// boundary only) and is always ready; the user must see it written between
// frames, as the block itself does not enforce it. Each pixel passes capture
// plus line store read, squared difference, then window update, line store
// write and accumulate; the next pixel is taken only after these. After the
// last pixel the result follows a set-up step, the bit-serial divider, a
// load step and the bit-serial square root; with a nonzero status it follows
// the set-up step. After reset the mask line store is cleared, one column a
// cycle, over all MAX_WIDTH columns before the first pixel is taken. A
// waiting result holds out_ch and in_ch stays not ready until it is taken.
// ----------------------------------------------------------------------------
module masked_rmse_accumulator #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 4,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mra_in_if.sink      in_ch,
  mra_out_if.source   out_ch,
  mra_cfg_if.sink     cfg_ch
);

  mra_pkg::cmd_t    cmd;
  mra_pkg::sts_t    sts;
  logic [3:0][15:0] img_s, ref_s;

  assign img_s = {in_ch.img_ch3, in_ch.img_ch2, in_ch.img_ch1, in_ch.img_ch0};
  assign ref_s = {in_ch.ref_ch3, in_ch.ref_ch2, in_ch.ref_ch1, in_ch.ref_ch0};

  assign cfg_ch.ready = 1'b1;

  mra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mra_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_ch.valid),
    .cfg_addr (cfg_ch.addr),
    .cfg_data (cfg_ch.data),
    .img_s    (img_s),
    .ref_s    (ref_s),
    .mask_in  (in_ch.mask_selected),
    .rmse     (out_ch.rmse),
    .status   (out_ch.status)
  );

endmodule

[design/mra_checker.sv]
// ----------------------------------------------------------------------------
// mra_checker
// Port-level checks of the masked rmse accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module mra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] rmse,
  input logic [1:0]  status
);

  // result word stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  // no pixel taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while result pending");

  // one pixel in flight at a time
  a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // error results carry a zero rmse
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != mra_pkg::ST_OK |-> rmse == 32'd0)
    else $error("nonzero rmse with error status");

endmodule

bind masked_rmse_accumulator mra_checker u_mra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .rmse      (out_ch.rmse),
  .status    (out_ch.status)
);

[bench/tb_masked_rmse_accumulator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_rmse_accumulator
// Streams frames of random and directed pixels through the masked rmse
// accumulator under many register settings. A scoreboard mirrors the frame
// state, line stores and final divide and root, and checks every result word.
// ----------------------------------------------------------------------------
module tb_masked_rmse_accumulator;

  typedef struct {
    logic [15:0] img [4];
    logic [15:0] ref_s [4];
    logic        sel;
  } pixel_t;

  typedef struct {
    logic [31:0] rmse;
    logic [1:0]  status;
  } rmse_word_t;

  class rmse_scoreboard;
    bit [2:0]    channels;
    bit [12:0]   width;
    bit [15:0]   height;
    bit          use_mask;
    bit          boundary;
    int unsigned col;
    int unsigned row;
    bit [63:0]   sq_sum;
    bit [31:0]   hits;
    bit          mask_rows [2][4096];
    bit [63:0]   diff_row [4096];
    bit [8:0]    win;
    bit [63:0]   diff_held;
    rmse_word_t  expected_q [$];
    int          errors;
    int          results_seen;

    function new();
      channels = mra_pkg::RST_CHANNELS;
      width = mra_pkg::RST_WIDTH;
      height = mra_pkg::RST_HEIGHT;
      foreach (diff_row[i]) diff_row[i] = '0;
      foreach (mask_rows[i, j]) mask_rows[i][j] = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        mra_pkg::REG_CHANNELS: channels = val[2:0];
        mra_pkg::REG_WIDTH:    width = val[12:0];
        mra_pkg::REG_HEIGHT:   height = val[15:0];
        mra_pkg::REG_USE_MASK: use_mask = val[0];
        mra_pkg::REG_BOUNDARY: boundary = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned n_eff();
      return channels == 0 ? 1 : (channels > 4 ? 4 : channels);
    endfunction

    function int unsigned w_eff();
      return width == 0 ? 1 : (width > 4096 ? 4096 : width);
    endfunction

    function int unsigned h_eff();
      return height == 0 ? 1 : height;
    endfunction

    function void add_hit(bit [63:0] sq);
      bit [64:0] t;
      t = sq_sum + sq;
      sq_sum = t[64] ? '1 : t[63:0];
      if (hits != '1) hits++;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      int unsigned n, w, h, c, r;
      bit [63:0] si, sr, ad, sq, above, centre;
      bit [2:0] colbits;
      bit [95:0] quot;
      rmse_word_t e;
      n = n_eff();
      w = w_eff();
      h = h_eff();
      c = col % 4096;
      r = row;
      si = 0;
      sr = 0;
      for (int k = 0; k < n; k++) begin
        si += p.img[k];
        sr += p.ref_s[k];
      end
      ad = si >= sr ? si - sr : sr - si;
      sq = ad * ad;
      colbits = {mask_rows[r & 1][c], mask_rows[(r + 1) & 1][c], p.sel};
      above = diff_row[c];
      centre = diff_held;
      win = {win[5:0], colbits};
      mask_rows[r & 1][c] = p.sel;
      diff_row[c] = sq;
      diff_held = above;
      if (use_mask && boundary) begin
        if (r >= 2 && c >= 2 && win != 9'h000 && win != 9'h1FF) add_hit(centre);
      end else if (!use_mask || p.sel) begin
        add_hit(sq);
      end
      if (col + 1 < w) begin
        col++;
        return;
      end
      col = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      e.rmse = '0;
      e.status = mra_pkg::ST_OK;
      if (use_mask && boundary && (w < 3 || h < 3)) begin
        e.status = mra_pkg::ST_SMALL;
      end else if (hits == 0) begin
        e.status = mra_pkg::ST_EMPTY;
      end else begin
        quot = {sq_sum, 32'd0} / (96'(n) * 96'(n) * 96'(hits));
        e.rmse = int_sqrt(quot[95:64] != 0 ? '1 : quot[63:0]);
      end
      expected_q.push_back(e);
      row = 0;
      sq_sum = 0;
      hits = 0;
      win = 0;
      diff_held = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [31:0] rmse, logic [1:0] status);
      rmse_word_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word rmse=%h status=%0d", rmse, status));
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, want %0d", status, e.status));
      if (rmse !== e.rmse)
        report($sformatf("rmse %h, want %h", rmse, e.rmse));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  mra_in_if  in_ch();
  mra_out_if out_ch();
  mra_cfg_if cfg_ch();

  masked_rmse_accumulator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  rmse_scoreboard sb;
  bit idling = 1'b1;
  int pixels_sent;
  int frames_sent;
  int x0, x1, y0, y1, val_style, mask_style;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #60ms;
    $display("tb_masked_rmse_accumulator: errors");
    $finish;
  end

  // result side: random back-pressure per word while idling is set
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = idling ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.rmse, out_ch.status);
    end
  end

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = idling ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.img_ch0 <= p.img[0];
    in_ch.img_ch1 <= p.img[1];
    in_ch.img_ch2 <= p.img[2];
    in_ch.img_ch3 <= p.img[3];
    in_ch.ref_ch0 <= p.ref_s[0];
    in_ch.ref_ch1 <= p.ref_s[1];
    in_ch.ref_ch2 <= p.ref_s[2];
    in_ch.ref_ch3 <= p.ref_s[3];
    in_ch.mask_selected <= p.sel;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  // drain the block, then write all registers; junk upper bits are masked off
  task automatic write_regs(int ch, int w, int h, bit um, bit bo);
    logic [15:0] vals [5];
    logic [2:0]  idxs [5];
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (12) @(posedge clk);
    idxs = '{mra_pkg::REG_CHANNELS, mra_pkg::REG_WIDTH, mra_pkg::REG_HEIGHT,
             mra_pkg::REG_USE_MASK, mra_pkg::REG_BOUNDARY};
    vals[0] = {13'($urandom_range(0, 8191)), 3'(ch)};
    vals[1] = {3'($urandom_range(0, 7)), 13'(w)};
    vals[2] = 16'(h);
    vals[3] = {15'($urandom_range(0, 32767)), um};
    vals[4] = {15'($urandom_range(0, 32767)), bo};
    for (int i = 0; i < 6; i++) begin
      cfg_ch.valid <= 1'b1;
      if (i < 5) begin
        cfg_ch.addr <= idxs[i];
        cfg_ch.data <= vals[i];
      end else begin
        // unused index, must change nothing
        cfg_ch.addr <= 3'($urandom_range(5, 7));
        cfg_ch.data <= 16'($urandom);
      end
      do @(posedge clk); while (!cfg_ch.ready);
      sb.set_reg(cfg_ch.addr, cfg_ch.data);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [15:0] draw_sample(logic [15:0] other);
    case (val_style)
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return other + 16'($urandom_range(0, 6)) - 16'd3;
    endcase
  endfunction

  task automatic run_frame();
    int w, h;
    pixel_t p;
    bit in_box;
    w = sb.w_eff();
    h = sb.h_eff();
    x0 = $urandom_range(0, w - 1);
    x1 = $urandom_range(x0, w - 1);
    y0 = $urandom_range(0, h - 1);
    y1 = $urandom_range(y0, h - 1);
    val_style = $urandom_range(0, 2);
    mask_style = $urandom_range(0, 9);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        for (int k = 0; k < 4; k++) begin
          p.img[k] = draw_sample(16'($urandom));
          p.ref_s[k] = draw_sample(p.img[k]);
        end
        in_box = x >= x0 && x <= x1 && y >= y0 && y <= y1;
        case (mask_style)
          0: p.sel = 1'b0;
          1: p.sel = 1'b1;
          2, 3: p.sel = 1'($urandom);
          default: p.sel = in_box ^ ($urandom_range(0, 19) == 0);
        endcase
        send_pixel(p);
      end
    end
    frames_sent++;
  endtask

  task automatic send_fixed(logic [15:0] iv, logic [15:0] rv, bit sel);
    pixel_t p;
    for (int k = 0; k < 4; k++) begin
      p.img[k] = iv;
      p.ref_s[k] = rv;
    end
    p.sel = sel;
    send_pixel(p);
  endtask

  initial begin
    int ch, w, h, pick;
    bit um, bo;
    sb = new();
    in_ch.valid <= 1'b0;
    in_ch.img_ch0 <= '0;
    in_ch.img_ch1 <= '0;
    in_ch.img_ch2 <= '0;
    in_ch.img_ch3 <= '0;
    in_ch.ref_ch0 <= '0;
    in_ch.ref_ch1 <= '0;
    in_ch.ref_ch2 <= '0;
    in_ch.ref_ch3 <= '0;
    in_ch.mask_selected <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr <= mra_pkg::REG_CHANNELS;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full-scale 3x3 frame on four channels
    write_regs(4, 3, 3, 1'b0, 1'b0);
    send_fixed(16'hFFFF, 16'h0000, 1'b1);
    send_fixed(16'h0000, 16'hFFFF, 1'b0);
    send_fixed(16'hFFFF, 16'hFFFF, 1'b1);
    send_fixed(16'h0000, 16'h0000, 1'b0);
    send_fixed(16'h8000, 16'h7FFF, 1'b1);
    send_fixed(16'h0001, 16'h0000, 1'b0);
    send_fixed(16'hFFFF, 16'h0000, 1'b0);
    send_fixed(16'h1234, 16'h4321, 1'b1);
    send_fixed(16'hFFFF, 16'h0000, 1'b1);
    // boundary mode on a 2x2 image: too small
    write_regs(1, 2, 2, 1'b1, 1'b1);
    repeat (4) send_fixed(16'h00FF, 16'h0000, 1'b1);
    // mask on, nothing selected: empty
    write_regs(2, 1, 1, 1'b1, 1'b0);
    send_fixed(16'hFFFF, 16'h0000, 1'b0);
    // zero channels, width and height act as one
    write_regs(0, 0, 0, 1'b0, 1'b0);
    send_fixed(16'hFFFF, 16'h0000, 1'b0);
    // channel count above range acts as four
    write_regs(7, 2, 1, 1'b0, 1'b1);
    send_fixed(16'hABCD, 16'h0000, 1'b0);
    send_fixed(16'h0000, 16'hFFFF, 1'b0);
    // smallest boundary frame, all selected: no boundary pixels
    write_regs(3, 3, 3, 1'b1, 1'b1);
    repeat (9) send_fixed(16'h0F0F, 16'h0000, 1'b1);

    // random frames, mostly small images
    while (pixels_sent < 1950) begin
      pick = $urandom_range(0, 19);
      ch = $urandom_range(0, 7);
      w = pick == 0 ? $urandom_range(20, 60) : $urandom_range(0, 9);
      h = pick == 1 ? $urandom_range(12, 30) : $urandom_range(0, 8);
      um = $urandom_range(0, 3) != 0;
      bo = $urandom_range(0, 2) != 0;
      idling = $urandom_range(0, 4) != 0;
      write_regs(ch, w, h, um, bo);
      repeat ($urandom_range(1, 3)) run_frame();
    end
    idling = 1'b1;

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (150) @(posedge clk);
    $display("run covered %0d frames, %0d pixels, %0d result words",
             frames_sent, pixels_sent, sb.results_seen);
    if (sb.errors == 0) begin
      $display("tb_masked_rmse_accumulator: clean");
    end else begin
      $display("tb_masked_rmse_accumulator: errors");
    end
    $finish;
  end
endmodule
